// ===== design/agns_pkg.sv =====
// ----------------------------------------------------------------------------
// agns_pkg
// Shared types and constants for the accelerometer g-force normalize and
// smoothing core: field widths, register indexes, divider sizing and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package agns_pkg;

  localparam int RAW_W   = 8;
  localparam int G_W     = 16;
  localparam int ALPHA_W = 16;
  localparam int AXES    = 3;
  localparam int AXIS_W  = 2;

  // Q4.11: one g is 2**FRAC_W; numerator is mag * 2 * 2048 + one_g
  localparam int FRAC_W     = 11;
  localparam int NUM_W      = RAW_W + FRAC_W + 1;    // 20
  localparam int DIVISOR_W  = RAW_W + 1;             // 2 * one_g
  localparam int DIV_STEPS  = NUM_W;
  localparam int CNT_W      = 5;

  localparam int DIFF_W     = G_W + 1;               // kept - instant
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int ADJ_W      = PROD_W - ALPHA_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_X        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_Y        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_Z        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_G_Z       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE = 3'd7;

  localparam logic [RAW_W-1:0]   ZERO_RESET   = 8'd128;
  localparam logic [RAW_W-1:0]   ONE_G_RESET  = 8'd26;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 16'd58982;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [G_W-1:0] G_MAX = 16'sh7FFF;
  localparam logic signed [G_W-1:0] G_MIN = 16'sh8000;

  typedef struct packed {
    logic [AXES-1:0][RAW_W-1:0] zero;
    logic [AXES-1:0][RAW_W-1:0] one_g;
    logic [ALPHA_W-1:0]         alpha;
    logic                       enable;
  } cfg_t;

  typedef struct packed {
    logic              capture;  // latch the raw sample
    logic              load;     // set up the divider for the current axis
    logic              step;     // one restoring-division step
    logic              sat;      // sign, clamp and store the instant value
    logic              mul;      // alpha * (kept - instant)
    logic              upd;      // write the new kept value
    logic [AXIS_W-1:0] axis;
  } dp_cmd_t;

endpackage

// ===== design/agns_ctrl.sv =====
// ----------------------------------------------------------------------------
// agns_ctrl
// Sequencer: walks the three axes through load, divide, clamp, multiply and
// update, then hands the finished result to the output register.
// ----------------------------------------------------------------------------
module agns_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  output logic                out_load,
  output agns_pkg::dp_cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SAT  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_DONE = 3'd6;

  logic [2:0]                    state_r, state_nxt;
  logic [agns_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [agns_pkg::AXIS_W-1:0]   axis_r, axis_nxt;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    axis_nxt    = axis_r;
    in_ready    = 1'b0;
    out_load    = 1'b0;
    cmd         = '0;
    cmd.axis    = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          axis_nxt    = agns_pkg::AXIS_X;
          state_nxt   = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == agns_pkg::CNT_W'(agns_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        cmd.sat   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (axis_r == agns_pkg::AXIS_Z) begin
          state_nxt = ST_DONE;
        end else begin
          axis_nxt  = axis_r + 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      ST_DONE: begin
        // hold until the output register can take the result
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

endmodule

// ===== design/agns_dp.sv =====
// ----------------------------------------------------------------------------
// agns_dp
// Datapath: per-axis offset removal, a shared bit-serial divider, clamping,
// and the smoothing multiply-accumulate on the kept vector.
// ----------------------------------------------------------------------------
module agns_dp (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  agns_pkg::dp_cmd_t                           cmd,
  input  agns_pkg::cfg_t                              cfg,
  input  logic [agns_pkg::RAW_W-1:0]                  in_raw_x,
  input  logic [agns_pkg::RAW_W-1:0]                  in_raw_y,
  input  logic [agns_pkg::RAW_W-1:0]                  in_raw_z,
  output logic signed [agns_pkg::G_W-1:0]             inst_g [agns_pkg::AXES],
  output logic signed [agns_pkg::G_W-1:0]             kept_g [agns_pkg::AXES]
);

  logic [agns_pkg::RAW_W-1:0]         raw_r [agns_pkg::AXES];
  logic signed [agns_pkg::G_W-1:0]    inst_r [agns_pkg::AXES];
  logic signed [agns_pkg::G_W-1:0]    kept_r [agns_pkg::AXES];

  logic [agns_pkg::NUM_W-1:0]         num_r;
  logic [agns_pkg::NUM_W-1:0]         quo_r;
  logic [agns_pkg::DIVISOR_W-1:0]     rem_r;
  logic [agns_pkg::DIVISOR_W-1:0]     dvs_r;
  logic                               neg_r;
  logic                               zdiv_r;
  logic                               zdiff_r;
  logic signed [agns_pkg::PROD_W-1:0] prod_r;

  logic [agns_pkg::RAW_W-1:0]         raw_sel, zero_sel, oneg_sel;
  logic [agns_pkg::RAW_W:0]           diff;
  logic [agns_pkg::RAW_W:0]           diff_abs;
  logic [agns_pkg::RAW_W-1:0]         mag;
  logic [agns_pkg::DIVISOR_W:0]       trial;
  logic                               qbit;
  logic signed [agns_pkg::G_W-1:0]    inst_new;
  logic signed [agns_pkg::G_W-1:0]    inst_sel, kept_sel;
  logic signed [agns_pkg::DIFF_W-1:0] delta;
  logic signed [agns_pkg::PROD_W-1:0] prod_rnd;
  logic signed [agns_pkg::ADJ_W-1:0]  adj;
  logic signed [agns_pkg::ADJ_W-1:0]  kept_new;

  always_comb begin
    unique case (cmd.axis)
      agns_pkg::AXIS_Y: begin
        raw_sel  = raw_r[1];
        zero_sel = cfg.zero[1];
        oneg_sel = cfg.one_g[1];
        inst_sel = inst_r[1];
        kept_sel = kept_r[1];
      end
      agns_pkg::AXIS_Z: begin
        raw_sel  = raw_r[2];
        zero_sel = cfg.zero[2];
        oneg_sel = cfg.one_g[2];
        inst_sel = inst_r[2];
        kept_sel = kept_r[2];
      end
      default: begin
        raw_sel  = raw_r[0];
        zero_sel = cfg.zero[0];
        oneg_sel = cfg.one_g[0];
        inst_sel = inst_r[0];
        kept_sel = kept_r[0];
      end
    endcase
  end

  assign diff     = {1'b0, raw_sel} - {1'b0, zero_sel};
  assign diff_abs = diff[agns_pkg::RAW_W] ? (~diff + 1'b1) : diff;
  assign mag      = diff_abs[agns_pkg::RAW_W-1:0];

  // restoring division step: bring down the next numerator bit
  assign trial = {rem_r, num_r[agns_pkg::NUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  always_comb begin
    if (zdiv_r) begin
      if (zdiff_r) begin
        inst_new = '0;
      end else begin
        inst_new = neg_r ? agns_pkg::G_MIN : agns_pkg::G_MAX;
      end
    end else if (neg_r) begin
      if (quo_r > agns_pkg::NUM_W'(32768)) begin
        inst_new = agns_pkg::G_MIN;
      end else begin
        inst_new = agns_pkg::G_W'(~quo_r + 1'b1);
      end
    end else begin
      if (quo_r > agns_pkg::NUM_W'(32767)) begin
        inst_new = agns_pkg::G_MAX;
      end else begin
        inst_new = quo_r[agns_pkg::G_W-1:0];
      end
    end
  end

  assign delta    = agns_pkg::DIFF_W'(kept_sel) - agns_pkg::DIFF_W'(inst_sel);
  assign prod_rnd = prod_r + agns_pkg::PROD_W'(32768);
  assign adj      = agns_pkg::ADJ_W'(prod_rnd >>> agns_pkg::ALPHA_W);
  assign kept_new = agns_pkg::ADJ_W'(inst_sel) + adj;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      raw_r[0] <= in_raw_x;
      raw_r[1] <= in_raw_y;
      raw_r[2] <= in_raw_z;
    end
    if (cmd.load) begin
      num_r   <= {mag, 4'b0000, oneg_sel};
      quo_r   <= '0;
      rem_r   <= '0;
      dvs_r   <= {oneg_sel, 1'b0};
      neg_r   <= diff[agns_pkg::RAW_W];
      zdiv_r  <= (oneg_sel == '0);
      zdiff_r <= (mag == '0);
    end
    if (cmd.step) begin
      num_r <= {num_r[agns_pkg::NUM_W-2:0], 1'b0};
      quo_r <= {quo_r[agns_pkg::NUM_W-2:0], qbit};
      rem_r <= qbit ? agns_pkg::DIVISOR_W'(trial - {1'b0, dvs_r})
                    : trial[agns_pkg::DIVISOR_W-1:0];
    end
    if (cmd.sat) begin
      inst_r[cmd.axis] <= inst_new;
    end
    if (cmd.mul) begin
      prod_r <= $signed({1'b0, cfg.alpha}) * delta;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r[0] <= '0;
      kept_r[1] <= '0;
      kept_r[2] <= '0;
    end else if (cmd.upd) begin
      kept_r[cmd.axis] <= cfg.enable ? kept_new[agns_pkg::G_W-1:0] : inst_sel;
    end
  end

  assign inst_g = inst_r;
  assign kept_g = kept_r;

endmodule

// ===== design/accel_gforce_normalize_smooth_core.sv =====
// ----------------------------------------------------------------------------
// accel_gforce_normalize_smooth_core
// Raw three-axis accelerometer counts to instant and smoothed g-force, Q4.11.
//
// Input channel in_*: one request carries raw_x/y/z. Output channel out_*:
// one request carries the instant vector and the smoothed vector after it.
// Both use valid/ready. Calibration registers are written through cfg_we,
// cfg_index and cfg_wdata while the core is idle, which the user must ensure;
// the core does not enforce it. They take effect at once. Each axis runs
// through one shared 20-step bit-serial divider plus load, clamp, multiply
// and update states. A new request is taken only once the previous sample
// has been handed to the output register.
// The result sits in an output register; while the receiver stalls, the core
// still accepts and computes the next sample and then holds it until the
// output register frees up.
// Reset (rst_n low, synchronous) restores the calibration defaults, clears
// the smoothed vector to zero and empties the output register.
// ----------------------------------------------------------------------------
module accel_gforce_normalize_smooth_core (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [agns_pkg::RAW_W-1:0]                in_raw_x,
  input  logic [agns_pkg::RAW_W-1:0]                in_raw_y,
  input  logic [agns_pkg::RAW_W-1:0]                in_raw_z,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic signed [agns_pkg::G_W-1:0]           out_inst_gx,
  output logic signed [agns_pkg::G_W-1:0]           out_inst_gy,
  output logic signed [agns_pkg::G_W-1:0]           out_inst_gz,
  output logic signed [agns_pkg::G_W-1:0]           out_filt_gx,
  output logic signed [agns_pkg::G_W-1:0]           out_filt_gy,
  output logic signed [agns_pkg::G_W-1:0]           out_filt_gz,
  input  logic                                      cfg_we,
  input  logic [agns_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [agns_pkg::CFG_DATA_W-1:0]           cfg_wdata
);

  agns_pkg::cfg_t                  cfg_r;
  agns_pkg::dp_cmd_t               cmd;
  logic                            out_valid_r;
  logic                            out_load;
  logic signed [agns_pkg::G_W-1:0] inst_g [agns_pkg::AXES];
  logic signed [agns_pkg::G_W-1:0] kept_g [agns_pkg::AXES];
  logic signed [agns_pkg::G_W-1:0] inst_x_r, inst_y_r, inst_z_r;
  logic signed [agns_pkg::G_W-1:0] filt_x_r, filt_y_r, filt_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.zero   <= {agns_pkg::AXES{agns_pkg::ZERO_RESET}};
      cfg_r.one_g  <= {agns_pkg::AXES{agns_pkg::ONE_G_RESET}};
      cfg_r.alpha  <= agns_pkg::ALPHA_RESET;
      cfg_r.enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        agns_pkg::REG_ZERO_X:  cfg_r.zero[0]  <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_ZERO_Y:  cfg_r.zero[1]  <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_ZERO_Z:  cfg_r.zero[2]  <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_ONE_G_X: cfg_r.one_g[0] <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_ONE_G_Y: cfg_r.one_g[1] <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_ONE_G_Z: cfg_r.one_g[2] <= cfg_wdata[agns_pkg::RAW_W-1:0];
        agns_pkg::REG_SMOOTH_ALPHA:
          cfg_r.alpha <= cfg_wdata[agns_pkg::ALPHA_W-1:0];
        agns_pkg::REG_SMOOTH_ENABLE:
          cfg_r.enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  agns_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (!out_valid_r || out_ready),
    .out_load (out_load),
    .cmd      (cmd)
  );

  agns_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .cfg      (cfg_r),
    .in_raw_x (in_raw_x),
    .in_raw_y (in_raw_y),
    .in_raw_z (in_raw_z),
    .inst_g   (inst_g),
    .kept_g   (kept_g)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      inst_x_r <= inst_g[0];
      inst_y_r <= inst_g[1];
      inst_z_r <= inst_g[2];
      filt_x_r <= kept_g[0];
      filt_y_r <= kept_g[1];
      filt_z_r <= kept_g[2];
    end
  end

  assign out_valid   = out_valid_r;
  assign out_inst_gx = inst_x_r;
  assign out_inst_gy = inst_y_r;
  assign out_inst_gz = inst_z_r;
  assign out_filt_gx = filt_x_r;
  assign out_filt_gy = filt_y_r;
  assign out_filt_gz = filt_z_r;

endmodule

// ===== tb/sv/accel_gforce_normalize_smooth_core_tb.sv =====
// ----------------------------------------------------------------------------
// accel_gforce_normalize_smooth_core_tb
// Self-checking bench for the accelerometer g-force normalize and smoothing
// core. Raw samples are pushed through the input channel while the bench
// keeps its own copy of the calibration and of the smoothed vector, and
// predicts the instant and smoothed g-force of every accepted sample. Each
// result is checked field by field. A directed part with register extremes
// and a zero divisor is followed by random calibration phases with random
// stalls on both sides.
// ----------------------------------------------------------------------------
module accel_gforce_normalize_smooth_core_tb;

  localparam int STALL_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 500;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 157;

  typedef struct packed {
    logic [agns_pkg::RAW_W-1:0] x;
    logic [agns_pkg::RAW_W-1:0] y;
    logic [agns_pkg::RAW_W-1:0] z;
  } raw_sample_t;

  typedef struct packed {
    logic signed [agns_pkg::G_W-1:0] ix;
    logic signed [agns_pkg::G_W-1:0] iy;
    logic signed [agns_pkg::G_W-1:0] iz;
    logic signed [agns_pkg::G_W-1:0] fx;
    logic signed [agns_pkg::G_W-1:0] fy;
    logic signed [agns_pkg::G_W-1:0] fz;
  } g_vec_t;

  logic                              clk       = 1'b0;
  logic                              rst_n     = 1'b0;
  logic                              in_valid  = 1'b0;
  logic                              in_ready;
  logic [agns_pkg::RAW_W-1:0]        in_raw_x  = '0;
  logic [agns_pkg::RAW_W-1:0]        in_raw_y  = '0;
  logic [agns_pkg::RAW_W-1:0]        in_raw_z  = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [agns_pkg::G_W-1:0]   out_inst_gx, out_inst_gy, out_inst_gz;
  logic signed [agns_pkg::G_W-1:0]   out_filt_gx, out_filt_gy, out_filt_gz;
  logic                              cfg_we    = 1'b0;
  logic [agns_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [agns_pkg::CFG_DATA_W-1:0]   cfg_wdata = '0;

  raw_sample_t sample_q[$];
  g_vec_t      gforce_q[$];

  // calibration mirror and smoothed vector of the predictor
  logic [agns_pkg::RAW_W-1:0]      cal_offset[agns_pkg::AXES];
  logic [agns_pkg::RAW_W-1:0]      cal_one_g[agns_pkg::AXES];
  logic [agns_pkg::ALPHA_W-1:0]    cal_alpha;
  logic                            cal_enable;
  logic signed [agns_pkg::G_W-1:0] smooth_vec[agns_pkg::AXES];

  int  n_samples    = 0;
  int  n_results    = 0;
  int  n_settings   = 0;
  int  n_mismatch   = 0;
  int  stall_cycles = 0;
  bit  no_idle      = 1'b0;
  bit  rx_hold_req  = 1'b0;

  accel_gforce_normalize_smooth_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .in_raw_z    (in_raw_z),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_inst_gx (out_inst_gx),
    .out_inst_gy (out_inst_gy),
    .out_inst_gz (out_inst_gz),
    .out_filt_gx (out_filt_gx),
    .out_filt_gy (out_filt_gy),
    .out_filt_gz (out_filt_gz),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata)
  );

  always #10 clk = ~clk;

  // (raw - zero) * 2048 / one_g, nearest with ties away from zero, clamped
  function automatic logic signed [agns_pkg::G_W-1:0] axis_gforce(
      logic [agns_pkg::RAW_W-1:0] raw,
      logic [agns_pkg::RAW_W-1:0] zero,
      logic [agns_pkg::RAW_W-1:0] one_g);
    int          diff;
    int unsigned mag;
    int unsigned quot;
    diff = int'(raw) - int'(zero);
    mag  = (diff < 0) ? -diff : diff;
    if (one_g == '0) begin
      if (diff == 0) return '0;
      return (diff < 0) ? agns_pkg::G_MIN : agns_pkg::G_MAX;
    end
    quot = (mag * 4096 + int'(one_g)) / (2 * int'(one_g));
    if (diff < 0) begin
      if (quot > 32768) quot = 32768;
      return agns_pkg::G_W'(-int'(quot));
    end
    if (quot > 32767) quot = 32767;
    return agns_pkg::G_W'(quot);
  endfunction

  // alpha * kept + (1 - alpha) * instant, nearest with ties toward +inf
  function automatic logic signed [agns_pkg::G_W-1:0] blend_axis(
      logic signed [agns_pkg::G_W-1:0] kept,
      logic signed [agns_pkg::G_W-1:0] inst);
    longint acc;
    if (!cal_enable) return inst;
    acc = longint'(cal_alpha) * longint'(kept)
        + (longint'(65536) - longint'(cal_alpha)) * longint'(inst);
    return agns_pkg::G_W'((acc + 32768) >>> 16);
  endfunction

  function automatic g_vec_t predict_gforce(raw_sample_t s);
    g_vec_t r;
    r.ix = axis_gforce(s.x, cal_offset[0], cal_one_g[0]);
    r.iy = axis_gforce(s.y, cal_offset[1], cal_one_g[1]);
    r.iz = axis_gforce(s.z, cal_offset[2], cal_one_g[2]);
    smooth_vec[0] = blend_axis(smooth_vec[0], r.ix);
    smooth_vec[1] = blend_axis(smooth_vec[1], r.iy);
    smooth_vec[2] = blend_axis(smooth_vec[2], r.iz);
    r.fx = smooth_vec[0];
    r.fy = smooth_vec[1];
    r.fz = smooth_vec[2];
    return r;
  endfunction

  // sender: hold a request until accepted, then maybe idle
  always @(posedge clk) begin : sender
    bit          fire;
    bit          take;
    raw_sample_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        nxt.x = in_raw_x;
        nxt.y = in_raw_y;
        nxt.z = in_raw_z;
        gforce_q.push_back(predict_gforce(nxt));
        n_samples++;
      end
      if (!in_valid || fire) begin
        take = (sample_q.size() != 0) && (no_idle || $urandom_range(0, 99) >= 9);
        if (take) begin
          nxt = sample_q.pop_front();
          in_raw_x <= nxt.x;
          in_raw_y <= nxt.y;
          in_raw_z <= nxt.z;
        end
        in_valid <= take;
      end
    end
  end

  // receiver: check each result, stall at random or for a long hold-off
  always @(posedge clk) begin : receiver
    int     hold_left;
    g_vec_t got;
    g_vec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_inst_gx, out_inst_gy, out_inst_gz,
               out_filt_gx, out_filt_gy, out_filt_gz};
        n_results++;
        if (gforce_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("unexpected result: inst %0d %0d %0d filt %0d %0d %0d",
                     got.ix, got.iy, got.iz, got.fx, got.fy, got.fz);
        end else begin
          want = gforce_q.pop_front();
          if (got.ix !== want.ix || got.iy !== want.iy || got.iz !== want.iz ||
              got.fx !== want.fx || got.fy !== want.fy || got.fz !== want.fz) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("mismatch on result %0d", n_results);
              $display("  expected inst %0d %0d %0d filt %0d %0d %0d",
                       want.ix, want.iy, want.iz, want.fx, want.fy, want.fz);
              $display("  actual   inst %0d %0d %0d filt %0d %0d %0d",
                       got.ix, got.iy, got.iz, got.fx, got.fy, got.fz);
            end
          end
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // watchdog: count cycles without progress while work is outstanding
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) ||
        (sample_q.size() == 0 && gforce_q.size() == 0 && !in_valid)) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("** accel_gforce_normalize_smooth_core: FAILED **");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  task automatic write_reg(logic [agns_pkg::CFG_IDX_W-1:0] idx, int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= agns_pkg::CFG_DATA_W'(data);
  endtask

  // write all eight registers and update the mirror
  task automatic apply_setting(int unsigned zx, int unsigned zy, int unsigned zz,
                               int unsigned gx, int unsigned gy, int unsigned gz,
                               int unsigned alpha, int unsigned en);
    write_reg(agns_pkg::REG_ZERO_X, zx);
    write_reg(agns_pkg::REG_ZERO_Y, zy);
    write_reg(agns_pkg::REG_ZERO_Z, zz);
    write_reg(agns_pkg::REG_ONE_G_X, gx);
    write_reg(agns_pkg::REG_ONE_G_Y, gy);
    write_reg(agns_pkg::REG_ONE_G_Z, gz);
    write_reg(agns_pkg::REG_SMOOTH_ALPHA, alpha);
    write_reg(agns_pkg::REG_SMOOTH_ENABLE, en);
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_offset[0] = agns_pkg::RAW_W'(zx);
    cal_offset[1] = agns_pkg::RAW_W'(zy);
    cal_offset[2] = agns_pkg::RAW_W'(zz);
    cal_one_g[0]  = agns_pkg::RAW_W'(gx);
    cal_one_g[1]  = agns_pkg::RAW_W'(gy);
    cal_one_g[2]  = agns_pkg::RAW_W'(gz);
    cal_alpha     = agns_pkg::ALPHA_W'(alpha);
    cal_enable    = en[0];
    n_settings++;
  endtask

  task automatic push_sample(int unsigned x, int unsigned y, int unsigned z);
    raw_sample_t s;
    s.x = agns_pkg::RAW_W'(x);
    s.y = agns_pkg::RAW_W'(y);
    s.z = agns_pkg::RAW_W'(z);
    sample_q.push_back(s);
  endtask

  // wait until every queued request has been sent and its result has come back
  task automatic wait_drained();
    while (sample_q.size() != 0 || in_valid || gforce_q.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  // mostly near the zero point so both clamp and fine steps show up
  function automatic int unsigned pick_raw(int unsigned zero, int unsigned one_g);
    int v;
    if ($urandom_range(0, 9) < 4) return $urandom_range(0, 255);
    v = int'(zero) + int'($urandom_range(0, 8 * one_g + 8)) - int'(4 * one_g + 4);
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v;
  endfunction

  function automatic int unsigned pick_one_g();
    case ($urandom_range(0, 7))
      0:       return 1;
      1:       return 255;
      2, 3:    return $urandom_range(1, 255);
      default: return $urandom_range(8, 64);
    endcase
  endfunction

  function automatic int unsigned pick_alpha();
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return 65535;
      2, 3:    return $urandom_range(0, 65535);
      default: return $urandom_range(40000, 65535);
    endcase
  endfunction

  initial begin
    cal_offset = '{agns_pkg::ZERO_RESET, agns_pkg::ZERO_RESET, agns_pkg::ZERO_RESET};
    cal_one_g  = '{agns_pkg::ONE_G_RESET, agns_pkg::ONE_G_RESET,
                   agns_pkg::ONE_G_RESET};
    cal_alpha  = agns_pkg::ALPHA_RESET;
    cal_enable = 1'b1;
    smooth_vec = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset calibration: full-scale and near-zero counts
    push_sample(0, 255, 128);
    push_sample(255, 0, 127);
    push_sample(129, 128, 1);
    push_sample(128, 128, 128);
    wait_drained();

    // zero points at the extremes, unit divisor to force both clamps, alpha zero
    apply_setting(0, 255, 128, 1, 1, 255, 0, 1);
    push_sample(255, 0, 0);
    push_sample(0, 255, 255);
    push_sample(1, 254, 128);
    push_sample(128, 128, 129);
    wait_drained();

    // zero divisor on every axis: positive, negative and zero difference
    apply_setting(100, 100, 255, 0, 0, 0, 65535, 1);
    push_sample(200, 0, 255);
    push_sample(0, 200, 0);
    push_sample(100, 100, 255);
    wait_drained();

    // smoothing off: kept vector copies the instant one
    apply_setting(255, 0, 128, 255, 2, 7, 12345, 0);
    push_sample(0, 255, 128);
    push_sample(255, 0, 200);
    push_sample(17, 99, 3);
    wait_drained();

    // back to the reset values, all written explicitly
    apply_setting(agns_pkg::ZERO_RESET, agns_pkg::ZERO_RESET, agns_pkg::ZERO_RESET,
                  agns_pkg::ONE_G_RESET, agns_pkg::ONE_G_RESET, agns_pkg::ONE_G_RESET,
                  agns_pkg::ALPHA_RESET, 1);
    push_sample(128, 128, 128);
    push_sample(200, 60, 90);
    push_sample(255, 255, 255);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin : rand_phase
      int unsigned zx, zy, zz, gx, gy, gz;
      zx = $urandom_range(0, 255);
      zy = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 255);
      zz = ($urandom_range(0, 5) == 0) ? 255 : $urandom_range(0, 255);
      gx = pick_one_g();
      gy = pick_one_g();
      gz = pick_one_g();
      apply_setting(zx, zy, zz, gx, gy, gz, pick_alpha(),
                    ($urandom_range(0, 3) == 0) ? 0 : 1);
      no_idle = (ph == 8);
      for (int i = 0; i < PHASE_ITEMS; i++)
        push_sample(pick_raw(zx, gx), pick_raw(zy, gy), pick_raw(zz, gz));
      // long receiver hold-off so the core backs up into its input
      if (ph == 5) rx_hold_req = 1'b1;
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (100) @(posedge clk);
    if (gforce_q.size() != 0) n_mismatch++;
    $display("%0d samples sent, %0d results checked over %0d calibration settings",
             n_samples, n_results, n_settings);
    $display("covered clamps, zero divisor, smoothing on and off, alpha extremes, %0d errors",
             n_mismatch);
    if (n_mismatch == 0) begin
      $display("** accel_gforce_normalize_smooth_core: PASSED **");
    end else begin
      $display("** accel_gforce_normalize_smooth_core: FAILED **");
    end
    $finish;
  end

endmodule
